@@ rtl/core/ffra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and codes of the first-fit rectangle allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LAYERS      = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_LAYER,
    ST_ROW_START,
    ST_ROW_RD,
    ST_ROW_CAP,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic load_req;
    logic layer_init;
    logic next_layer;
    logic row_init;
    logic next_row;
    logic row_cap;
    logic scan_step;
    logic mark_wr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad_req;
    logic layers_done;
    logic rows_done;
    logic last_row;
    logic hit;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/ffra_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_dpath
// Occupancy row memory, row accumulator, column scanner and result register.
// ----------------------------------------------------------------------------
module ffra_dpath import ffra_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_LAYERS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic [8:0]         req_width,
  input  logic [8:0]         req_height,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               placed,
  output logic [7:0]         pos_x,
  output logic [7:0]         pos_y,
  output logic [1:0]         layer
);

  localparam int Depth = MAX_LAYERS * MAX_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int LW    = $clog2(MAX_LAYERS + 1);

  logic [MAX_WIDTH-1:0] mem [Depth];
  logic [MAX_WIDTH-1:0] rdata;

  logic [8:0]  cfg_w, cfg_h;
  logic [2:0]  cfg_l;
  logic [8:0]  rw, rh;
  logic [DW-1:0] gw;
  logic [HW-1:0] gh;
  logic [LW-1:0] nl;
  logic [LW-1:0] z;
  logic [AW-1:0] base;
  logic [HW-1:0] y, yi;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] row_addr, addr;
  logic [MAX_WIDTH-1:0] acc, colbit, mask;
  logic [CW-1:0] col, fx;
  logic [DW-1:0] run;
  logic          found;
  logic          free_bit;

  assign row_addr = base + AW'(y) + AW'(yi);
  assign addr     = cmd.clear_wr ? clr_addr : row_addr;
  assign free_bit = !acc[0];

  // Occupancy: one row of a layer per word
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      mem[addr] <= '0;
    end else if (cmd.mark_wr) begin
      mem[addr] <= rdata | mask;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= 9'd256;
      cfg_h    <= 9'd256;
      cfg_l    <= 3'd4;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  cfg_w <= cfg_data;
          REG_GRID_HEIGHT: cfg_h <= cfg_data;
          REG_LAYERS:      cfg_l <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cmd.clear_wr) clr_addr <= clr_addr + 1'b1;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rw    <= req_width;
      rh    <= req_height;
      gw    <= (32'(cfg_w) > MAX_WIDTH)  ? DW'(MAX_WIDTH)  : DW'(cfg_w);
      gh    <= (32'(cfg_h) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_h);
      nl    <= (32'(cfg_l) > MAX_LAYERS) ? LW'(MAX_LAYERS) : LW'(cfg_l);
      z     <= '0;
      base  <= '0;
      found <= 1'b0;
    end
    if (cmd.next_layer) begin
      z    <= z + 1'b1;
      base <= base + AW'(MAX_HEIGHT);
    end
    if (cmd.layer_init) y <= '0;
    if (cmd.next_row)   y <= y + 1'b1;
    if (cmd.row_init) begin
      yi  <= '0;
      acc <= '0;
    end
    if (cmd.row_cap) begin
      acc    <= acc | rdata;
      yi     <= sts.last_row ? '0 : yi + 1'b1;
      col    <= '0;
      run    <= '0;
      colbit <= MAX_WIDTH'(1);
      mask   <= '0;
    end
    if (cmd.scan_step) begin
      acc    <= acc >> 1;
      col    <= col + 1'b1;
      colbit <= colbit << 1;
      run    <= free_bit ? run + 1'b1 : '0;
      mask   <= free_bit ? (mask | colbit) : '0;
      if (sts.hit) fx <= CW'(32'(col) + 32'd1 - 32'(rw));
    end
    if (cmd.mark_wr) begin
      yi <= yi + 1'b1;
      if (sts.last_row) found <= 1'b1;
    end
    if (cmd.emit) begin
      placed <= found;
      pos_x  <= found ? 8'(fx) : 8'd0;
      pos_y  <= found ? 8'(y)  : 8'd0;
      layer  <= found ? 2'(z)  : 2'd0;
    end
  end

  always_comb begin
    sts.clr_last    = (32'(clr_addr) == Depth - 1);
    sts.bad_req     = (rw == 9'd0) || (rh == 9'd0) ||
                      (32'(rw) > 32'(gw)) || (32'(rh) > 32'(gh));
    sts.layers_done = (32'(z) >= 32'(nl));
    sts.rows_done   = (32'(y) + 32'(rh) > 32'(gh));
    sts.last_row    = (32'(yi) + 32'd1 == 32'(rh));
    sts.hit         = free_bit && (32'(run) + 32'd1 == 32'(rw));
    sts.scan_end    = (32'(col) + 32'd1 == 32'(gw));
    sts.out_free    = !out_valid || !out_stall;
  end

endmodule

@@ rtl/core/ffra_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer of the clearing pass, the search and the marking of a request.
// ----------------------------------------------------------------------------
module ffra_ctrl import ffra_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd,
  output state_t state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = sts.bad_req ? ST_DONE : ST_LAYER;
      end
      ST_LAYER: begin
        if (sts.layers_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.layer_init = 1'b1;
          state_next     = ST_ROW_START;
        end
      end
      ST_ROW_START: begin
        if (sts.rows_done) begin
          cmd.next_layer = 1'b1;
          state_next     = ST_LAYER;
        end else begin
          cmd.row_init = 1'b1;
          state_next   = ST_ROW_RD;
        end
      end
      ST_ROW_RD: begin
        state_next = ST_ROW_CAP;
      end
      ST_ROW_CAP: begin
        cmd.row_cap = 1'b1;
        state_next  = sts.last_row ? ST_SCAN : ST_ROW_RD;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          state_next = ST_MARK_RD;
        end else if (sts.scan_end) begin
          cmd.next_row = 1'b1;
          state_next   = ST_ROW_START;
        end
      end
      ST_MARK_RD: begin
        state_next = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_next  = sts.last_row ? ST_DONE : ST_MARK_RD;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

@@ rtl/core/first_fit_rectangle_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_rectangle_allocator_unit
// First-fit placement of rectangles into a layered occupancy bitmap.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              beat
//  in       receive    in_valid / in_stall    req_width, req_height
//  out      send       out_valid / out_stall  placed, pos_x, pos_y, layer
//  cfg      receive    cfg_we                 cfg_index, cfg_data
//
// One request at a time. Per layer and start row the unit first tests
// whether the rows fit, reads req_height rows (address, then OR into the
// accumulator), then scans one column a cycle up to grid_width; a hit
// marks each row with a read, then a write. After reset a clearing pass
// zeroes all MAX_LAYERS*MAX_HEIGHT words of the memory; in_stall stays
// high meanwhile. A stalled result is held in the output register while
// the unit takes the next request.
// ----------------------------------------------------------------------------
module first_fit_rectangle_allocator_unit import ffra_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_LAYERS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         req_width,
  input  logic [8:0]         req_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               placed,
  output logic [7:0]         pos_x,
  output logic [7:0]         pos_y,
  output logic [1:0]         layer
);

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  // Sequence the search; only commands and status cross over
  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // Hold the bitmap, the scan registers and the result beat
  ffra_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_width  (req_width),
    .req_height (req_height),
    .cmd        (cmd),
    .sts        (sts),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .placed     (placed),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .layer      (layer)
  );

  // A failed placement reports the origin of layer zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !placed) |-> (pos_x == 8'd0 && pos_y == 8'd0 && layer == 2'd0))
    else $error("unplaced beat carries a non-zero position");

  // An accepted request makes the unit busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while the previous one is in flight");

  // Nothing is taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall)
    else $error("request taken during the clearing pass");

  // A result is loaded only once the search has finished
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == ST_DONE && !in_stall == 1'b0))
    else $error("result loaded outside the finishing step");

endmodule

@@ tb/ffra_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_checker
// Watches the request, result and register ports of the allocator, keeps a
// shadow occupancy bitmap, predicts each placement and compares the results.
// ----------------------------------------------------------------------------
module ffra_checker import ffra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [8:0]         req_width,
  input  logic [8:0]         req_height,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               placed,
  input  logic [7:0]         pos_x,
  input  logic [7:0]         pos_y,
  input  logic [1:0]         layer,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic       placed;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [1:0] layer;
  } placement_t;

  // One 256-bit word per row of each layer.
  logic [255:0] shadow_occ [4][256];
  logic [8:0]   grid_w;
  logic [8:0]   grid_h;
  logic [2:0]   n_layers;
  placement_t   placement_q [$];
  int           fails = 0;

  assign fail_count = fails;
  assign pending    = placement_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  function automatic placement_t place_rect(input logic [8:0] rw, input logic [8:0] rh);
    placement_t res;
    int gw, gh, nl;
    logic [256:0] mask;
    logic [255:0] rows_or;
    res = '0;
    gw = (grid_w > 256) ? 256 : grid_w;
    gh = (grid_h > 256) ? 256 : grid_h;
    nl = (n_layers > 4) ? 4 : n_layers;
    if (rw == 0 || rh == 0 || rw > gw || rh > gh) return res;
    mask = (257'd1 << rw) - 257'd1;
    for (int z = 0; z < nl; z++) begin
      for (int y = 0; y + rh <= gh; y++) begin
        rows_or = '0;
        for (int r = y; r < y + rh; r++) rows_or |= shadow_occ[z][r];
        for (int x = 0; x + rw <= gw; x++) begin
          if (((rows_or >> x) & mask[255:0]) == '0) begin
            // Mark the whole rectangle as used.
            for (int r = y; r < y + rh; r++) shadow_occ[z][r] |= mask[255:0] << x;
            res.placed = 1'b1;
            res.pos_x  = x[7:0];
            res.pos_y  = y[7:0];
            res.layer  = z[1:0];
            return res;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    placement_t predicted;
    if (rst) begin
      for (int z = 0; z < 4; z++)
        for (int r = 0; r < 256; r++) shadow_occ[z][r] = '0;
      grid_w   = 9'd256;
      grid_h   = 9'd256;
      n_layers = 3'd4;
      placement_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:  grid_w = cfg_data;
          REG_GRID_HEIGHT: grid_h = cfg_data;
          REG_LAYERS:      n_layers = cfg_data[2:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (placement_q.size() == 0) begin
          report_mismatch("result beat count", 1, 0);
        end else begin
          want = placement_q.pop_front();
          if (placed !== want.placed) report_mismatch("placed", placed, want.placed);
          if (pos_x !== want.pos_x) report_mismatch("pos_x", pos_x, want.pos_x);
          if (pos_y !== want.pos_y) report_mismatch("pos_y", pos_y, want.pos_y);
          if (layer !== want.layer) report_mismatch("layer", layer, want.layer);
        end
      end
      if (in_valid && !in_stall) begin
        predicted   = place_rect(req_width, req_height);
        placement_q = {placement_q, predicted};
      end
    end
  end

endmodule

@@ tb/tb_first_fit_rectangle_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_rectangle_allocator_unit
// Drives rectangle requests and register writes into the allocator, with
// random gaps and back-pressure; a checker beside the unit does the scoring.
// ----------------------------------------------------------------------------
module tb_first_fit_rectangle_allocator_unit;
  import ffra_pkg::*;

  // Index with no register behind it.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [8:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [8:0]         req_width;
  logic [8:0]         req_height;
  logic               out_valid;
  logic               out_stall;
  logic               placed;
  logic [7:0]         pos_x;
  logic [7:0]         pos_y;
  logic [1:0]         layer;
  int                 fail_count;
  int                 pending;

  // Effective grid as the stimulus sees it, to keep the search cost sane.
  int                 eff_w;
  int                 eff_h;
  int                 stall_left;

  always #4 clk = ~clk;

  first_fit_rectangle_allocator_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_width(req_width),
    .req_height(req_height), .out_valid(out_valid), .out_stall(out_stall),
    .placed(placed), .pos_x(pos_x), .pos_y(pos_y), .layer(layer)
  );

  ffra_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_width(req_width),
    .req_height(req_height), .out_valid(out_valid), .out_stall(out_stall),
    .placed(placed), .pos_x(pos_x), .pos_y(pos_y), .layer(layer),
    .fail_count(fail_count), .pending(pending)
  );

  // Pick a gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Back-pressure on the result side: bursts of stall, stretches of none.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      out_stall  <= 1'b0;
    end
  end

  // Send one request beat; keep valid high across back-to-back beats.
  task automatic send_rect(input logic [8:0] rw, input logic [8:0] rh);
    int gap;
    gap = pick_gap();
    if (gap > 0 && in_valid) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_width  <= rw;
    req_height <= rh;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, drain every outstanding result, then let the unit settle.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Hold the write enable; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [8:0] gw, input logic [8:0] gh, input logic [2:0] nl);
    drain();
    write_reg(REG_GRID_WIDTH, gw);
    write_reg(REG_GRID_HEIGHT, gh);
    write_reg(REG_LAYERS, {6'd0, nl});
    cfg_we <= 1'b0;
    @(posedge clk);
    eff_w = (gw > 256) ? 256 : gw;
    eff_h = (gh > 256) ? 256 : gh;
  endtask

  // Random size along one axis: mostly inside the grid, sometimes over or zero.
  function automatic logic [8:0] rand_size(input int limit);
    int roll;
    int top;
    roll = $urandom_range(0, 99);
    top  = (limit < 1) ? 1 : ((limit > 12) ? 12 : limit);
    if (roll < 5) return 9'd0;
    if (roll < 12) return 9'(limit + $urandom_range(1, 3));
    return 9'($urandom_range(1, top));
  endfunction

  task automatic random_phase(input int count);
    logic [8:0] rw;
    logic [8:0] rh;
    for (int i = 0; i < count; i++) begin
      rw = rand_size(eff_w);
      rh = rand_size(eff_h);
      // Random widths over the full 9-bit range only when the grid is short.
      if (eff_h <= 16 && $urandom_range(0, 9) == 0) rw = 9'($urandom_range(0, 511));
      send_rect(rw, rh);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_GRID_WIDTH;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    req_width  <= '0;
    req_height <= '0;
    eff_w = 256;
    eff_h = 256;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset grid of 256 x 256 on four layers.
    send_rect(9'd256, 9'd256);  // fills layer 0
    send_rect(9'd1, 9'd1);      // full scan of layer 0, lands on layer 1
    send_rect(9'd0, 9'd5);      // empty rectangle
    send_rect(9'd5, 9'd0);
    send_rect(9'd257, 9'd1);    // wider than the grid
    send_rect(9'd1, 9'd257);
    send_rect(9'd511, 9'd511);
    send_rect(9'd1, 9'd256);    // last start row is row zero
    send_rect(9'd255, 9'd1);
    send_rect(9'd170, 9'd85);

    // Saturation, empty grid, no layers and an ignored index.
    set_grid(9'd511, 9'd4, 3'd7);
    write_reg(REG_UNUSED, 9'd1);
    cfg_we <= 1'b0;
    send_rect(9'd256, 9'd1);
    send_rect(9'd3, 9'd4);
    random_phase(16);
    set_grid(9'd0, 9'd8, 3'd4);
    send_rect(9'd1, 9'd1);
    set_grid(9'd8, 9'd0, 3'd4);
    send_rect(9'd1, 9'd1);
    set_grid(9'd8, 9'd8, 3'd0);
    send_rect(9'd1, 9'd1);

    // Random phases over several grid shapes.
    set_grid(9'd16, 9'd16, 3'd4);
    random_phase(24);
    set_grid(9'd8, 9'd511, 3'd2);
    random_phase(16);
    set_grid(9'd1, 9'd1, 3'd7);
    random_phase(8);
    set_grid(9'd20, 9'd10, 3'd3);
    random_phase(24);
    set_grid(9'd24, 9'd24, 3'd1);
    random_phase(12);
    set_grid(9'd32, 9'd12, 3'd4);
    random_phase(24);
    set_grid(9'd6, 9'd6, 3'd4);
    random_phase(16);

    drain();
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #60ms;
    $display("Verification failed");
    $finish;
  end

endmodule
